@@ design/dcd_pkg.sv @@
`default_nettype none

package dcd_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VTX_W        = $clog2(MAX_VERTICES);
   localparam int POS_W        = $clog2(MAX_VERTICES + 1);
   localparam int STK_W        = POS_W + VTX_W;

   localparam int FIELD_VTX_W  = 6;
   localparam int CNT_W        = 7;
   localparam int STATUS_W     = 2;

   localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

   localparam logic KIND_EDGE  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_STORED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 2'd2;

   localparam int GRP_W = 8;
   localparam int GRP_N = (MAX_VERTICES + GRP_W - 1) / GRP_W;

   // lowest set bit: pick the first nonzero group, then the first bit inside it
   function automatic logic [VTX_W-1:0] first_set(input logic [MAX_VERTICES-1:0] bits);
      logic [GRP_N*GRP_W-1:0] padded;
      logic [GRP_N-1:0]       grp_nz;
      logic [GRP_W-1:0]       grp_bits;
      int                     g_sel;
      int                     b_sel;
      padded = '0;
      padded[MAX_VERTICES-1:0] = bits;
      for (int g = 0; g < GRP_N; g++) begin
         grp_nz[g] = |padded[g*GRP_W +: GRP_W];
      end
      g_sel = 0;
      for (int g = GRP_N - 1; g >= 0; g--) begin
         if (grp_nz[g]) begin
            g_sel = g;
         end
      end
      grp_bits = padded[g_sel*GRP_W +: GRP_W];
      b_sel = 0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            b_sel = b;
         end
      end
      return VTX_W'(g_sel * GRP_W + b_sel);
   endfunction

endpackage

`default_nettype wire

@@ design/dcd_channels.sv @@
`default_nettype none

interface dcd_req_if import dcd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [FIELD_VTX_W-1:0] from_vertex;
   logic [FIELD_VTX_W-1:0] to_vertex;

   modport source (output valid, output kind, output from_vertex, output to_vertex,
                   input ready);
   modport sink   (input valid, input kind, input from_vertex, input to_vertex,
                   output ready);
endinterface

interface dcd_rsp_if import dcd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                cyclic;

   modport source (output valid, output status, output cyclic, input ready);
   modport sink   (input valid, input status, input cyclic, output ready);
endinterface

`default_nettype wire

@@ design/dcd_ram.sv @@
`default_nettype none

module dcd_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/directed_cycle_detector_core.sv @@
// Directed cycle detector. Each req transaction either adds the edge
// from_vertex -> to_vertex to a 64x64 adjacency matrix kept in a synchronous
// RAM, or (kind 1) asks whether the stored graph restricted to vertices below
// csr vertex_count holds a directed cycle; every request returns exactly one
// rsp transaction. An accepted edge store passes through the row write
// (ST_EDGE) and ST_DONE before its result is valid; a rejected edge goes
// straight to ST_DONE. A query runs an iterative depth-first search over the
// adjacency and stack RAMs, whose reads are registered: ST_ROOT picks a root,
// ST_LOAD loads a row, ST_SCAN takes one live edge per step and ST_POP
// returns to a parent. The search stops at the first back edge. Requests
// are taken one at a time; a finished result waits in the output register
// while the next request is accepted. The adjacency matrix reads as empty
// after reset without a clearing pass. The user must write vertex_count only
// while no request is in flight; the block itself does not enforce it.
`default_nettype none

module directed_cycle_detector_core import dcd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   dcd_req_if.sink          req_ch,
   dcd_rsp_if.source        rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EDGE, ST_ROOT, ST_LOAD, ST_SCAN, ST_POP, ST_DONE
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [MAX_VERTICES-1:0] row_vld_ff;
   logic                    row_hit_ff;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [MAX_VERTICES-1:0] onpath_ff;
   logic [MAX_VERTICES-1:0] rest_ff;
   logic [VTX_W-1:0]        top_v_ff;
   logic [POS_W-1:0]        pos_ff;
   logic [POS_W-1:0]        depth_ff;
   logic [POS_W-1:0]        root_ff;
   logic [VTX_W-1:0]        edge_from_ff;
   logic [VTX_W-1:0]        edge_to_ff;
   logic [STATUS_W-1:0]     res_status_ff;
   logic                    res_cyclic_ff;
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic                    rsp_cyclic_ff;

   logic [CNT_W-1:0]        n_act;
   logic [MAX_VERTICES-1:0] live;
   logic [MAX_VERTICES-1:0] scan_keep;
   logic [MAX_VERTICES-1:0] row_rd_data;
   logic [MAX_VERTICES-1:0] row_eff;
   logic [MAX_VERTICES-1:0] row_wr_data;
   logic [VTX_W-1:0]        row_rd_addr;
   logic                    row_wr_en;
   logic [STK_W-1:0]        stk_rd_data;
   logic [STK_W-1:0]        stk_wr_data;
   logic                    stk_wr_en;
   logic [POS_W-1:0]        depth_m1;
   logic [POS_W-1:0]        depth_m2;
   logic [VTX_W-1:0]        w_idx;
   logic [POS_W-1:0]        pos_next;
   logic [VTX_W-1:0]        pop_v;
   logic [POS_W-1:0]        pop_pos;
   logic                    edge_bad;
   logic                    req_take;
   logic                    rsp_free;

   assign n_act = (count_ff > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_ff;

   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         live[i]      = CNT_W'(i) < n_act;
         scan_keep[i] = POS_W'(i) >= pos_ff;
      end
   end

   assign req_take = req_ch.valid && (state_ff == ST_IDLE);
   assign edge_bad = (CNT_W'(req_ch.from_vertex) >= n_act)
                  || (CNT_W'(req_ch.to_vertex) >= n_act);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign row_eff     = row_hit_ff ? row_rd_data : '0;
   assign row_wr_en   = (state_ff == ST_EDGE);
   assign row_wr_data = row_eff | (MAX_VERTICES'(1) << edge_to_ff);

   assign w_idx    = first_set(rest_ff);
   assign pos_next = POS_W'(w_idx) + POS_W'(1);
   assign depth_m1 = depth_ff - POS_W'(1);
   assign depth_m2 = depth_ff - POS_W'(2);
   assign pop_v    = stk_rd_data[VTX_W-1:0];
   assign pop_pos  = stk_rd_data[STK_W-1:VTX_W];

   assign stk_wr_data = {pos_next, top_v_ff};
   assign stk_wr_en   = (state_ff == ST_SCAN) && (rest_ff != '0)
                     && !onpath_ff[w_idx] && !visited_ff[w_idx]
                     && (depth_ff < POS_W'(MAX_VERTICES));

   always_comb begin
      unique case (state_ff)
         ST_IDLE: row_rd_addr = req_ch.from_vertex[VTX_W-1:0];
         ST_ROOT: row_rd_addr = root_ff[VTX_W-1:0];
         ST_SCAN: row_rd_addr = w_idx;
         ST_POP:  row_rd_addr = pop_v;
         default: row_rd_addr = edge_from_ff;
      endcase
   end

   dcd_ram #(.DATA_W(MAX_VERTICES), .ADDR_W(VTX_W)) u_adj_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (edge_from_ff),
      .wr_data (row_wr_data),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_data)
   );

   dcd_ram #(.DATA_W(STK_W), .ADDR_W(VTX_W)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (depth_m1[VTX_W-1:0]),
      .wr_data (stk_wr_data),
      .rd_addr (depth_m2[VTX_W-1:0]),
      .rd_data (stk_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         row_vld_ff   <= '0;
         row_hit_ff   <= 1'b0;
         visited_ff   <= '0;
         onpath_ff    <= '0;
         depth_ff     <= '0;
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_hit_ff <= row_vld_ff[row_rd_addr];
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (rsp_ch.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  edge_from_ff <= req_ch.from_vertex[VTX_W-1:0];
                  edge_to_ff   <= req_ch.to_vertex[VTX_W-1:0];
                  if (req_ch.kind == KIND_QUERY) begin
                     visited_ff <= '0;
                     onpath_ff  <= '0;
                     depth_ff   <= '0;
                     root_ff    <= '0;
                     state_ff   <= ST_ROOT;
                  end else if (edge_bad) begin
                     res_status_ff <= STATUS_REJECTED;
                     res_cyclic_ff <= 1'b0;
                     state_ff      <= ST_DONE;
                  end else begin
                     state_ff <= ST_EDGE;
                  end
               end
            end
            ST_EDGE: begin
               row_vld_ff[edge_from_ff] <= 1'b1;
               res_status_ff            <= STATUS_STORED;
               res_cyclic_ff            <= 1'b0;
               state_ff                 <= ST_DONE;
            end
            ST_ROOT: begin
               if (CNT_W'(root_ff) >= n_act) begin
                  res_status_ff <= STATUS_ANSWERED;
                  res_cyclic_ff <= 1'b0;
                  depth_ff      <= '0;
                  state_ff      <= ST_DONE;
               end else if (visited_ff[root_ff[VTX_W-1:0]]) begin
                  root_ff <= root_ff + POS_W'(1);
               end else begin
                  visited_ff[root_ff[VTX_W-1:0]] <= 1'b1;
                  onpath_ff[root_ff[VTX_W-1:0]]  <= 1'b1;
                  top_v_ff <= root_ff[VTX_W-1:0];
                  pos_ff   <= '0;
                  depth_ff <= POS_W'(1);
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               rest_ff  <= row_eff & live & scan_keep;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (rest_ff == '0) begin
                  onpath_ff[top_v_ff] <= 1'b0;
                  depth_ff            <= depth_m1;
                  if (depth_ff == POS_W'(1)) begin
                     root_ff  <= root_ff + POS_W'(1);
                     state_ff <= ST_ROOT;
                  end else begin
                     state_ff <= ST_POP;
                  end
               end else if (onpath_ff[w_idx]) begin
                  res_status_ff <= STATUS_ANSWERED;
                  res_cyclic_ff <= 1'b1;
                  depth_ff      <= '0;
                  state_ff      <= ST_DONE;
               end else if (!visited_ff[w_idx]) begin
                  if (depth_ff >= POS_W'(MAX_VERTICES)) begin
                     res_status_ff <= STATUS_ANSWERED;
                     res_cyclic_ff <= 1'b1;
                     depth_ff      <= '0;
                     state_ff      <= ST_DONE;
                  end else begin
                     visited_ff[w_idx] <= 1'b1;
                     onpath_ff[w_idx]  <= 1'b1;
                     top_v_ff <= w_idx;
                     pos_ff   <= '0;
                     depth_ff <= depth_ff + POS_W'(1);
                     state_ff <= ST_LOAD;
                  end
               end else begin
                  rest_ff <= rest_ff & (rest_ff - MAX_VERTICES'(1));
               end
            end
            ST_POP: begin
               top_v_ff <= pop_v;
               pos_ff   <= pop_pos;
               state_ff <= ST_LOAD;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_cyclic_ff <= res_cyclic_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.cyclic = rsp_cyclic_ff;

endmodule

`default_nettype wire

@@ design/dcd_checker.sv @@
`default_nettype none

module dcd_checker import dcd_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_cyclic
);

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_STORED) || (rsp_status == STATUS_REJECTED)
                 || (rsp_status == STATUS_ANSWERED))
      else $error("rsp status code out of range");

   a_cyclic_only_on_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_ANSWERED) |-> !rsp_cyclic)
      else $error("cyclic set on an edge result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_cyclic))
      else $error("rsp transaction dropped or changed under stall");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while previous transaction still in work");

endmodule

bind directed_cycle_detector_core dcd_checker u_dcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_cyclic (rsp_ch.cyclic)
);

`default_nettype wire

@@ bench/tb_directed_cycle_detector_core.sv @@
`default_nettype none

module tb_directed_cycle_detector_core;
   import dcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 900;

   typedef struct packed {
      logic                   kind;
      logic [FIELD_VTX_W-1:0] from_vertex;
      logic [FIELD_VTX_W-1:0] to_vertex;
   } edge_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                cyclic;
   } answer_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   dcd_req_if req_bus ();
   dcd_rsp_if rsp_bus ();

   directed_cycle_detector_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus)
   );

   logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
   logic [CNT_W-1:0]        model_count;
   edge_req_type            request_backlog [$];
   answer_type              pending_answers [$];
   edge_req_type            next_req;
   edge_req_type            taken_req;
   answer_type              want;
   int                      gap_left;
   int                      stall_left;
   int                      errors;
   int                      random_sent;
   int                      threshold;
   logic                    calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int idle_draw();
      if (calm || $urandom_range(0, 3) == 0) begin
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic graph_has_cycle(input logic [CNT_W-1:0] n);
      logic [MAX_VERTICES-1:0] live;
      logic [MAX_VERTICES-1:0] seen;
      logic [MAX_VERTICES-1:0] on_path;
      logic [MAX_VERTICES-1:0] rest;
      int                      stk_v   [MAX_VERTICES];
      int                      stk_pos [MAX_VERTICES];
      int                      depth;
      int                      v;
      int                      w;
      live    = (n >= MAX_VERTICES) ? {MAX_VERTICES{1'b1}}
                                    : (({{(MAX_VERTICES-1){1'b0}}, 1'b1} << n) - 1'b1);
      seen    = '0;
      on_path = '0;
      for (int root = 0; root < n; root++) begin
         if (seen[root]) continue;
         seen[root]    = 1'b1;
         on_path[root] = 1'b1;
         stk_v[0]      = root;
         stk_pos[0]    = 0;
         depth         = 1;
         while (depth > 0) begin
            v    = stk_v[depth-1];
            rest = adj_rows[v] & live;
            if (stk_pos[depth-1] >= MAX_VERTICES) begin
               rest = '0;
            end else begin
               rest = rest & ({MAX_VERTICES{1'b1}} << stk_pos[depth-1]);
            end
            if (rest == '0) begin
               on_path[v] = 1'b0;
               depth--;
            end else begin
               w = 0;
               while (!rest[w]) w++;
               stk_pos[depth-1] = w + 1;
               if (on_path[w]) return 1'b1;
               if (!seen[w]) begin
                  if (depth >= MAX_VERTICES) return 1'b1;
                  seen[w]        = 1'b1;
                  on_path[w]     = 1'b1;
                  stk_v[depth]   = w;
                  stk_pos[depth] = 0;
                  depth++;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic answer_type detector_answer(input edge_req_type item);
      answer_type       ans;
      logic [CNT_W-1:0] n;
      n          = (model_count > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : model_count;
      ans.cyclic = 1'b0;
      if (item.kind == KIND_QUERY) begin
         ans.status = STATUS_ANSWERED;
         ans.cyclic = graph_has_cycle(n);
      end else if (item.from_vertex >= n || item.to_vertex >= n) begin
         ans.status = STATUS_REJECTED;
      end else begin
         adj_rows[item.from_vertex][item.to_vertex] = 1'b1;
         ans.status = STATUS_STORED;
      end
      return ans;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = idle_draw();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken_req = '{kind: req_bus.kind, from_vertex: req_bus.from_vertex,
                          to_vertex: req_bus.to_vertex};
            pending_answers = {pending_answers, detector_answer(taken_req)};
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               req_bus.valid <= 1'b0;
               gap_left--;
            end else if (request_backlog.size() != 0) begin
               next_req = request_backlog.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.kind        <= next_req.kind;
               req_bus.from_vertex <= next_req.from_vertex;
               req_bus.to_vertex   <= next_req.to_vertex;
               gap_left = idle_draw();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_answers.size() == 0) begin
               $display("%t unexpected response status %0d cyclic %0d", $time,
                        rsp_bus.status, rsp_bus.cyclic);
               errors++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_bus.status !== want.status) begin
                  $display("%t status mismatch expected %0d actual %0d", $time,
                           want.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.cyclic !== want.cyclic) begin
                  $display("%t cyclic mismatch expected %0d actual %0d", $time,
                           want.cyclic, rsp_bus.cyclic);
                  errors++;
               end
            end
            stall_left = idle_draw();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic queue_item(input logic kind, input int from_v, input int to_v);
      edge_req_type item;
      item = '{kind: kind, from_vertex: FIELD_VTX_W'(from_v),
               to_vertex: FIELD_VTX_W'(to_v)};
      request_backlog = {request_backlog, item};
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_bus.valid || pending_answers.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] value);
      model_count = value;
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   // the threshold branch draws back edges only from vertices at or above threshold;
   // the other edges run upward or touch a vertex at or above the current count
   task automatic queue_random_item(input int ne);
      int r;
      int a;
      int b;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         queue_item(KIND_QUERY, $urandom_range(0, 63), $urandom_range(0, 63));
      end else if ((r < 25 || ne < 2) && ne < MAX_VERTICES) begin
         a = $urandom_range(0, 63);
         b = $urandom_range(ne, 63);
         if ($urandom_range(0, 1) == 1) begin
            queue_item(KIND_EDGE, a, b);
         end else begin
            queue_item(KIND_EDGE, b, a);
         end
      end else if (r < 37 && ne > threshold) begin
         a = $urandom_range(threshold, ne - 1);
         b = $urandom_range(0, a);
         queue_item(KIND_EDGE, a, b);
      end else begin
         a = $urandom_range(0, ne - 2);
         b = $urandom_range(a + 1, ne - 1);
         queue_item(KIND_EDGE, a, b);
      end
   endtask

   initial begin
      int r;
      int cnt;
      int lo;
      int hi;
      int len;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_EDGE;
      req_bus.from_vertex = '0;
      req_bus.to_vertex   = '0;
      rsp_bus.ready       = 1'b0;
      errors              = 0;
      random_sent         = 0;
      calm                = 1'b0;
      model_count         = COUNT_RESET;
      for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset count: empty graph, cycle on the top pair, self-loop, duplicate
      queue_item(KIND_QUERY, 0, 0);
      queue_item(KIND_EDGE, 62, 63);
      queue_item(KIND_EDGE, 63, 62);
      queue_item(KIND_QUERY, 63, 63);
      queue_item(KIND_EDGE, 63, 63);
      queue_item(KIND_EDGE, 63, 63);
      queue_item(KIND_EDGE, 0, 1);
      queue_item(KIND_QUERY, 0, 0);
      wait_drained();
      // lowered count hides the top cycle; endpoints past the count bounce
      write_count(7'd63);
      queue_item(KIND_QUERY, 0, 0);
      queue_item(KIND_EDGE, 63, 0);
      queue_item(KIND_EDGE, 0, 63);
      queue_item(KIND_EDGE, 62, 62);
      queue_item(KIND_QUERY, 0, 0);
      wait_drained();
      write_count(7'd62);
      queue_item(KIND_QUERY, 0, 0);
      wait_drained();
      write_count(7'd1);
      queue_item(KIND_EDGE, 0, 1);
      queue_item(KIND_EDGE, 1, 0);
      queue_item(KIND_QUERY, 0, 0);
      wait_drained();
      write_count(7'd0);
      queue_item(KIND_EDGE, 0, 0);
      queue_item(KIND_QUERY, 0, 0);
      wait_drained();
      write_count(7'd127);
      queue_item(KIND_EDGE, 63, 63);
      queue_item(KIND_QUERY, 0, 0);

      threshold = 60;
      while (random_sent < RANDOM_ITEMS) begin
         wait_drained();
         calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 15);
         if (r == 0) begin
            cnt = 0;
         end else if (r == 1) begin
            cnt = $urandom_range(65, 127);
         end else if (r == 2) begin
            cnt = MAX_VERTICES;
         end else if (r == 3) begin
            cnt = 1;
         end else begin
            lo  = (threshold - 8 < 2) ? 2 : threshold - 8;
            hi  = (threshold + 8 > MAX_VERTICES) ? MAX_VERTICES : threshold + 8;
            cnt = $urandom_range(lo, hi);
         end
         write_count(CNT_W'(cnt));
         len = $urandom_range(10, 40);
         repeat (len) begin
            queue_random_item((cnt > MAX_VERTICES) ? MAX_VERTICES : cnt);
            random_sent++;
         end
         threshold = threshold - $urandom_range(0, 3);
         if (threshold < 4) threshold = 4;
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
design/dcd_pkg.sv
design/dcd_channels.sv
design/dcd_ram.sv
design/directed_cycle_detector_core.sv
design/dcd_checker.sv
bench/tb_directed_cycle_detector_core.sv
